// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the longest window block.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on every rising clock edge out of reset
`define LWKD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication
`define LWKD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hdl/lwkd_pkg.sv =====
// Shared constants and types of the longest window block.
// No dependencies; every other file but assert_macros.svh refers to it by scoped names.
package lwkd_pkg;

  localparam int WINDOW_DEPTH_DEF  = 4096;
  localparam int ALPHABET_SIZE_DEF = 256;

  localparam int SYM_W      = 8;
  localparam int LEN_OUT_W  = 13;
  localparam int BEST_W     = 16;
  localparam int MAXD_W     = 8;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // register word index, taken from paddr above the byte lanes
  localparam logic [CFG_ADDR_W-3:0] REG_MAX_DISTINCT = 1'b0;
  localparam logic [MAXD_W-1:0]     MAX_DISTINCT_RST = 8'd2;

  localparam logic [LEN_OUT_W-1:0] LEN_OUT_MAX = '1;
  localparam logic [BEST_W-1:0]    BEST_MAX    = '1;

  // queued symbol, already reduced to the alphabet
  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             last;
  } item_t;

endpackage

// ===== hdl/lwkd_if.sv =====
// Valid/ready channel interfaces for symbols in and results out.
// Depends on lwkd_pkg for the field widths.
interface lwkd_in_if;
  logic                        valid;
  logic                        ready;
  logic [lwkd_pkg::SYM_W-1:0]  symbol;
  logic                        last_symbol;

  modport source (output valid, symbol, last_symbol, input ready);
  modport sink   (input valid, symbol, last_symbol, output ready);
endinterface

interface lwkd_out_if;
  logic                            valid;
  logic                            ready;
  logic [lwkd_pkg::LEN_OUT_W-1:0]  window_length;
  logic [lwkd_pkg::BEST_W-1:0]     best_length;
  logic                            is_final;
  logic                            overflow;

  modport source (output valid, window_length, best_length, is_final, overflow,
                  input ready);
  modport sink   (input valid, window_length, best_length, is_final, overflow,
                  output ready);
endinterface

// ===== hdl/lwkd_regs.sv =====
// APB-style configuration register holding the distinct-symbol limit.
// Depends on lwkd_pkg for the address map and reset value.
module lwkd_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lwkd_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [lwkd_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [lwkd_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready,
  output logic [lwkd_pkg::MAXD_W-1:0]         max_distinct
);

  logic [lwkd_pkg::MAXD_W-1:0] max_distinct_r;
  logic [lwkd_pkg::MAXD_W-1:0] max_distinct_nxt;
  logic                        sel_max;

  // decode the word address, byte lanes ignored
  assign sel_max = (paddr[lwkd_pkg::CFG_ADDR_W-1:2] == lwkd_pkg::REG_MAX_DISTINCT);

  // take a write in the access phase
  always_comb begin
    max_distinct_nxt = max_distinct_r;
    if (psel && penable && pwrite && sel_max) begin
      max_distinct_nxt = pwdata[lwkd_pkg::MAXD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_distinct_r <= lwkd_pkg::MAX_DISTINCT_RST;
    end else begin
      max_distinct_r <= max_distinct_nxt;
    end
  end

  assign pready       = 1'b1;
  assign prdata       = sel_max ? lwkd_pkg::CFG_DATA_W'(max_distinct_r) : '0;
  assign max_distinct = max_distinct_r;

endmodule

// ===== hdl/lwkd_front.sv =====
// Front end: accepts symbols, reduces them to the alphabet and queues them.
// Depends on lwkd_pkg and lwkd_in_if; feeds the window engine in lwkd_back.
module lwkd_front #(
  parameter int ALPHABET_SIZE = lwkd_pkg::ALPHABET_SIZE_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  lwkd_in_if.sink              in_ch,
  output logic                 head_vld,
  output lwkd_pkg::item_t      head,
  input  logic                 head_pop
);

  localparam int NSYM = 2 ** lwkd_pkg::SYM_W;

  logic [lwkd_pkg::SYM_W-1:0] mod_tab [NSYM];
  lwkd_pkg::item_t            q_r [2];
  lwkd_pkg::item_t            item_in;
  logic                       wr_ptr_r, wr_ptr_nxt;
  logic                       rd_ptr_r, rd_ptr_nxt;
  logic [1:0]                 cnt_r, cnt_nxt;
  logic                       push;

  // symbol reduction table, worked out at elaboration
  for (genvar g = 0; g < NSYM; g++) begin : g_mod
    assign mod_tab[g] = lwkd_pkg::SYM_W'(g % ALPHABET_SIZE);
  end

  assign item_in.sym  = mod_tab[in_ch.symbol];
  assign item_in.last = in_ch.last_symbol;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign head_vld    = (cnt_r != 2'd0);
  assign head        = q_r[rd_ptr_r];

  // advance pointers and fill level
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = head_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    case ({push, head_pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // hold queued items
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

// ===== hdl/lwkd_back.sv =====
// Window engine: byte ring buffer, per-symbol counts and the result register.
// Depends on lwkd_pkg and lwkd_out_if; takes queued items from lwkd_front.
module lwkd_back #(
  parameter int WINDOW_DEPTH  = lwkd_pkg::WINDOW_DEPTH_DEF,
  parameter int ALPHABET_SIZE = lwkd_pkg::ALPHABET_SIZE_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         head_vld,
  input  lwkd_pkg::item_t              head,
  output logic                         head_pop,
  input  logic [lwkd_pkg::MAXD_W-1:0]  max_distinct,
  lwkd_out_if.source                   out_ch
);

  localparam int PTR_W  = $clog2(WINDOW_DEPTH);
  localparam int LEN_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int SYM_RW = $clog2(ALPHABET_SIZE);
  localparam int DIST_W = $clog2(ALPHABET_SIZE + 1);
  localparam int CMP_W  = (LEN_W > lwkd_pkg::BEST_W) ? LEN_W : lwkd_pkg::BEST_W;
  localparam int DCMP_W = 9;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DSYM = 3'd1;
  localparam logic [2:0] S_DCNT = 3'd2;
  localparam logic [2:0] S_AREQ = 3'd3;
  localparam logic [2:0] S_ACNT = 3'd4;
  localparam logic [2:0] S_DREQ = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  // memories
  logic [SYM_RW-1:0] win_mem [WINDOW_DEPTH];
  logic [LEN_W-1:0]  cnt_mem [ALPHABET_SIZE];
  logic [SYM_RW-1:0] win_q;
  logic [LEN_W-1:0]  cnt_q;
  logic              cnt_vq;

  // memory controls
  logic              win_re, win_we;
  logic [PTR_W-1:0]  win_raddr;
  logic              cnt_re, cnt_we;
  logic [SYM_RW-1:0] cnt_raddr, cnt_waddr;
  logic [LEN_W-1:0]  cnt_wdata, cnt_cur;

  // state
  logic [2:0]                    state_r, state_nxt;
  logic [SYM_RW-1:0]             sym_r, sym_nxt;
  logic                          last_r, last_nxt;
  logic                          ovf_mode_r, ovf_mode_nxt;
  logic [PTR_W-1:0]              wp_r, wp_nxt;
  logic [PTR_W-1:0]              sp_r, sp_nxt;
  logic [LEN_W-1:0]              len_r, len_nxt;
  logic [DIST_W-1:0]             dist_r, dist_nxt;
  logic [lwkd_pkg::BEST_W-1:0]   best_r, best_nxt;
  logic                          ovf_r, ovf_nxt;
  logic [ALPHABET_SIZE-1:0]      cnt_vld_r, cnt_vld_nxt;

  // result register
  logic                             out_vld_r, out_vld_nxt;
  logic                             out_load;
  logic [lwkd_pkg::LEN_OUT_W-1:0]   out_len_r, out_len_nxt;
  logic [lwkd_pkg::BEST_W-1:0]      out_best_r;
  logic                             out_fin_r;
  logic                             out_ovf_r;

  // saturation of the reported lengths
  logic [CMP_W-1:0]                 len_c;
  logic [lwkd_pkg::BEST_W-1:0]      best_upd, best_fin;

  assign cnt_cur = cnt_vq ? cnt_q : '0;

  assign len_c    = CMP_W'(len_r);
  assign best_upd = (len_c > CMP_W'(lwkd_pkg::BEST_MAX)) ? lwkd_pkg::BEST_MAX
                                                         : lwkd_pkg::BEST_W'(len_c);
  assign best_fin = (len_c > CMP_W'(best_r)) ? best_upd : best_r;
  assign out_len_nxt = (len_c > CMP_W'(lwkd_pkg::LEN_OUT_MAX)) ? lwkd_pkg::LEN_OUT_MAX
                                                               : lwkd_pkg::LEN_OUT_W'(len_c);

  // sequence add, drop and report for one symbol
  always_comb begin
    state_nxt    = state_r;
    sym_nxt      = sym_r;
    last_nxt     = last_r;
    ovf_mode_nxt = ovf_mode_r;
    wp_nxt       = wp_r;
    sp_nxt       = sp_r;
    len_nxt      = len_r;
    dist_nxt     = dist_r;
    best_nxt     = best_r;
    ovf_nxt      = ovf_r;
    cnt_vld_nxt  = cnt_vld_r;
    head_pop     = 1'b0;
    win_re       = 1'b0;
    win_raddr    = sp_r;
    win_we       = 1'b0;
    cnt_re       = 1'b0;
    cnt_raddr    = sym_r;
    cnt_we       = 1'b0;
    cnt_waddr    = sym_r;
    cnt_wdata    = cnt_cur + 1'b1;
    out_load     = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (head_vld) begin
          head_pop = 1'b1;
          sym_nxt  = head.sym[SYM_RW-1:0];
          last_nxt = head.last;
          if (len_r == LEN_W'(WINDOW_DEPTH)) begin
            // buffer full: drop the oldest byte before adding
            ovf_nxt      = 1'b1;
            ovf_mode_nxt = 1'b1;
            win_re       = 1'b1;
            state_nxt    = S_DSYM;
          end else begin
            cnt_re    = 1'b1;
            cnt_raddr = head.sym[SYM_RW-1:0];
            state_nxt = S_ACNT;
          end
        end
      end

      S_DSYM: begin
        // fetch the count of the byte leaving the window
        cnt_re    = 1'b1;
        cnt_raddr = win_q;
        state_nxt = S_DCNT;
      end

      S_DCNT: begin
        cnt_waddr = win_q;
        cnt_wdata = cnt_cur - 1'b1;
        sp_nxt    = (sp_r == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : sp_r + 1'b1;
        len_nxt   = len_r - 1'b1;
        if (cnt_cur != '0) begin
          cnt_we = 1'b1;
          if ((cnt_cur == LEN_W'(1)) && (dist_r != '0)) begin
            dist_nxt = dist_r - 1'b1;
          end
        end
        if (ovf_mode_r) begin
          ovf_mode_nxt = 1'b0;
          state_nxt    = S_AREQ;
        end else if ((DCMP_W'(dist_nxt) > DCMP_W'(max_distinct)) && (len_nxt != '0)) begin
          win_re    = 1'b1;
          win_raddr = sp_nxt;
          state_nxt = S_DSYM;
        end else begin
          state_nxt = S_FIN;
        end
      end

      S_AREQ: begin
        cnt_re    = 1'b1;
        state_nxt = S_ACNT;
      end

      S_ACNT: begin
        // append the symbol and bump its count
        cnt_we              = 1'b1;
        cnt_vld_nxt[sym_r]  = 1'b1;
        win_we              = 1'b1;
        wp_nxt  = (wp_r == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : wp_r + 1'b1;
        len_nxt = len_r + 1'b1;
        if (cnt_cur == '0) begin
          dist_nxt = dist_r + 1'b1;
        end
        if (DCMP_W'(dist_nxt) > DCMP_W'(max_distinct)) begin
          state_nxt = S_DREQ;
        end else begin
          state_nxt = S_FIN;
        end
      end

      S_DREQ: begin
        win_re    = 1'b1;
        state_nxt = S_DSYM;
      end

      S_FIN: begin
        if (!out_vld_r || out_ch.ready) begin
          out_load  = 1'b1;
          best_nxt  = best_fin;
          state_nxt = S_IDLE;
          if (last_r) begin
            // end of string: clear the window state
            wp_nxt      = '0;
            sp_nxt      = '0;
            len_nxt     = '0;
            dist_nxt    = '0;
            best_nxt    = '0;
            ovf_nxt     = 1'b0;
            cnt_vld_nxt = '0;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_vld_nxt = (out_vld_r && !out_ch.ready) || out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      ovf_mode_r <= 1'b0;
      wp_r       <= '0;
      sp_r       <= '0;
      len_r      <= '0;
      dist_r     <= '0;
      best_r     <= '0;
      ovf_r      <= 1'b0;
      cnt_vld_r  <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      ovf_mode_r <= ovf_mode_nxt;
      wp_r       <= wp_nxt;
      sp_r       <= sp_nxt;
      len_r      <= len_nxt;
      dist_r     <= dist_nxt;
      best_r     <= best_nxt;
      ovf_r      <= ovf_nxt;
      cnt_vld_r  <= cnt_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // hold the current item
  always_ff @(posedge clk) begin
    sym_r  <= sym_nxt;
    last_r <= last_nxt;
  end

  // load the result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_len_r  <= out_len_nxt;
      out_best_r <= best_fin;
      out_fin_r  <= last_r;
      out_ovf_r  <= ovf_r;
    end
  end

  // window byte ring buffer
  always_ff @(posedge clk) begin
    if (win_we) begin
      win_mem[wp_r] <= sym_r;
    end
    if (win_re) begin
      win_q <= win_mem[win_raddr];
    end
  end

  // per-symbol counts; an entry without its valid bit reads as zero
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (cnt_re) begin
      cnt_q  <= cnt_mem[cnt_raddr];
      cnt_vq <= cnt_vld_r[cnt_raddr];
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.window_length = out_len_r;
  assign out_ch.best_length   = out_best_r;
  assign out_ch.is_final      = out_fin_r;
  assign out_ch.overflow      = out_ovf_r;

endmodule

// ===== hdl/longest_window_k_distinct.sv =====
// Top level of the longest window block: register port, front end, engine.
// Depends on lwkd_pkg, lwkd_if, lwkd_regs, lwkd_front, lwkd_back, assert_macros.svh.
`include "assert_macros.svh"
//
// Usage:
//   in_ch carries one byte of a string per request (symbol, last_symbol).
//   out_ch returns exactly one result per byte: current window length,
//   longest window of the string so far, the final-byte mark and the
//   overflow flag. max_distinct is written over the APB port at address 0
//   while the block is idle; it resets to 2.
// Sequence:
//   A symbol that drops nothing passes the engine as a count read, a count
//   update with the buffer write, and the result load. Each byte dropped from
//   the left takes a buffer read and a count read-modify-write, after a step
//   that starts the shrink; a full buffer first forces out its oldest byte.
//   The engine takes the next symbol from the queue only after the result
//   load.
// Reset and stalls:
//   Synchronous active-low reset empties the queue and the window and clears
//   every count valid bit at once; no clearing pass is needed. A two-entry
//   queue keeps accepting while the engine works; a stalled receiver holds
//   the result register, then the engine, then the queue and in_ch.ready.
module longest_window_k_distinct #(
  parameter int WINDOW_DEPTH  = lwkd_pkg::WINDOW_DEPTH_DEF,
  parameter int ALPHABET_SIZE = lwkd_pkg::ALPHABET_SIZE_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  lwkd_in_if.sink                          in_ch,
  lwkd_out_if.source                       out_ch,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lwkd_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [lwkd_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [lwkd_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready
);

  localparam int OVF_BEST = (WINDOW_DEPTH > 65535) ? 65535 : WINDOW_DEPTH;

  logic                        head_vld;
  lwkd_pkg::item_t             head;
  logic                        head_pop;
  logic [lwkd_pkg::MAXD_W-1:0] max_distinct;

  lwkd_regs u_regs (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .max_distinct (max_distinct)
  );

  lwkd_front #(
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .head_vld (head_vld),
    .head     (head),
    .head_pop (head_pop)
  );

  lwkd_back #(
    .WINDOW_DEPTH  (WINDOW_DEPTH),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_vld     (head_vld),
    .head         (head),
    .head_pop     (head_pop),
    .max_distinct (max_distinct),
    .out_ch       (out_ch)
  );

  // the current window never beats the best one of its string
  `LWKD_ASSERT_IMP(a_len_le_best, out_ch.valid,
    lwkd_pkg::BEST_W'(out_ch.window_length) <= out_ch.best_length,
    "window length above best length")

  // an empty window only happens with a limit of zero
  `LWKD_ASSERT_IMP(a_empty_needs_zero_limit, out_ch.valid && (out_ch.window_length == '0),
    max_distinct == '0, "empty window with a nonzero limit")

  // overflow means the window once filled the whole buffer
  `LWKD_ASSERT_IMP(a_ovf_implies_full, out_ch.valid && out_ch.overflow,
    out_ch.best_length >= lwkd_pkg::BEST_W'(OVF_BEST), "overflow without a full window")

endmodule

// ===== verif/tb_top.sv =====
// Self-checking bench for longest_window_k_distinct: a streaming model of the
// at-most-k-distinct sliding window predicts every result, a checker compares it.
// Depends on lwkd_pkg, lwkd_if and the block's RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = lwkd_pkg::WINDOW_DEPTH_DEF;
  localparam int ALPHA       = lwkd_pkg::ALPHABET_SIZE_DEF;
  localparam int RANDOM_SYMS = 1700;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [lwkd_pkg::CFG_ADDR_W-1:0] LIMIT_ADDR = {lwkd_pkg::REG_MAX_DISTINCT, 2'b00};

  typedef struct packed {
    logic [lwkd_pkg::LEN_OUT_W-1:0] window_length;
    logic [lwkd_pkg::BEST_W-1:0]    best_length;
    logic                           is_final;
    logic                           overflow;
  } window_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [lwkd_pkg::CFG_ADDR_W-1:0] paddr;
  logic [lwkd_pkg::CFG_DATA_W-1:0] pwdata, prdata;
  logic pready;

  lwkd_in_if  in_ch();
  lwkd_out_if out_ch();

  longest_window_k_distinct dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Window model state, cleared at the end of each string
  int unsigned sym_count [ALPHA];
  logic [7:0]  win_bytes [DEPTH];
  int unsigned head_ptr, tail_ptr, n_distinct, win_len, best_len;
  logic        ovf_seen;
  logic [lwkd_pkg::MAXD_W-1:0] limit_model;

  window_result_t pending_windows[$];

  int  fail_count;
  int  n_results;
  int  n_strings;
  int  n_symbols;
  int  stall_cycles;
  bit  in_gaps_on;
  bit  out_gaps_on;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------- model
  function void clear_string();
    foreach (sym_count[i]) sym_count[i] = 0;
    head_ptr   = 0;
    tail_ptr   = 0;
    n_distinct = 0;
    win_len    = 0;
    best_len   = 0;
    ovf_seen   = 1'b0;
  endfunction

  // Drop the oldest byte from the left of the window
  function void drop_left();
    logic [7:0] s;
    if (win_len == 0) return;
    s = win_bytes[tail_ptr];
    tail_ptr = (tail_ptr + 1) % DEPTH;
    win_len--;
    if (sym_count[s] > 0) begin
      sym_count[s]--;
      if (sym_count[s] == 0 && n_distinct > 0) n_distinct--;
    end
  endfunction

  function window_result_t predict_window(input logic [7:0] s, input logic lst);
    window_result_t r;
    // full buffer: force out the oldest byte and flag it for the rest of the string
    if (win_len >= DEPTH) begin
      drop_left();
      ovf_seen = 1'b1;
    end
    win_bytes[head_ptr] = s;
    head_ptr = (head_ptr + 1) % DEPTH;
    win_len++;
    if (sym_count[s] == 0) n_distinct++;
    sym_count[s]++;
    // shrink from the left until the distinct limit holds
    while (n_distinct > limit_model && win_len > 0) drop_left();
    if (win_len > best_len) best_len = (win_len > lwkd_pkg::BEST_MAX) ? lwkd_pkg::BEST_MAX : win_len;
    r.window_length = (win_len > lwkd_pkg::LEN_OUT_MAX) ? lwkd_pkg::LEN_OUT_MAX
                                                       : win_len[lwkd_pkg::LEN_OUT_W-1:0];
    r.best_length   = best_len[lwkd_pkg::BEST_W-1:0];
    r.is_final      = lst;
    r.overflow      = ovf_seen;
    if (lst) clear_string();
    return r;
  endfunction

  // ------------------------------------------------------ predict and check
  always @(posedge clk) begin
    window_result_t want;
    if (rst_n) begin
      // record each accepted request before looking at results
      if (in_ch.valid && in_ch.ready) begin
        pending_windows.push_back(predict_window(in_ch.symbol, in_ch.last_symbol));
        n_symbols++;
        if (in_ch.last_symbol) n_strings++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_windows.size() == 0) begin
          $error("result arrived with no request outstanding");
          fail_count++;
        end else begin
          want = pending_windows.pop_front();
          n_results++;
          if (out_ch.window_length !== want.window_length) begin
            $error("window_length: expected %0d, got %0d", want.window_length, out_ch.window_length);
            fail_count++;
          end
          if (out_ch.best_length !== want.best_length) begin
            $error("best_length: expected %0d, got %0d", want.best_length, out_ch.best_length);
            fail_count++;
          end
          if (out_ch.is_final !== want.is_final) begin
            $error("is_final: expected %0d, got %0d", want.is_final, out_ch.is_final);
            fail_count++;
          end
          if (out_ch.overflow !== want.overflow) begin
            $error("overflow: expected %0d, got %0d", want.overflow, out_ch.overflow);
            fail_count++;
          end
        end
      end
    end
  end

  // Result receiver: long hold-off when asked, random stalls otherwise
  always @(negedge clk) begin
    if (stall_cycles > 0) begin
      out_ch.ready <= 1'b0;
      stall_cycles--;
    end else begin
      out_ch.ready <= !(out_gaps_on && $urandom_range(99) < 14);
    end
  end

  // ------------------------------------------------------------- drivers
  // Offer one symbol, with random gaps ahead of it when input gaps are on, and hold until accepted
  task automatic send_symbol(input logic [7:0] s, input logic lst);
    @(negedge clk);
    if (in_gaps_on) begin
      while ($urandom_range(99) < 14) begin
        in_ch.valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_ch.valid       <= 1'b1;
    in_ch.symbol      <= s;
    in_ch.last_symbol <= lst;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid and wait until every request has its result
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_windows.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_read(output logic [lwkd_pkg::CFG_DATA_W-1:0] d);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= LIMIT_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    d = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write the distinct limit (junk in the upper lanes), then read it back
  task automatic set_limit(input logic [lwkd_pkg::MAXD_W-1:0] lim);
    logic [lwkd_pkg::CFG_DATA_W-1:0] rd;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LIMIT_ADDR;
    pwdata  <= {16'($urandom_range(16'hFFFF)), 8'($urandom_range(255)), lim};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    limit_model = lim;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_read(rd);
    if (rd[lwkd_pkg::MAXD_W-1:0] !== lim) begin
      $error("max_distinct: expected %0d, got %0d", lim, rd[lwkd_pkg::MAXD_W-1:0]);
      fail_count++;
    end
  endtask

  // One string drawn mostly from a small pool of bytes, with some noise
  task automatic send_string(input int len, input int pool_n, input int noise_pct);
    logic [7:0] pool[16];
    logic [7:0] s;
    foreach (pool[i]) pool[i] = 8'($urandom_range(255));
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < noise_pct) s = 8'($urandom_range(255));
      else s = pool[$urandom_range(pool_n - 1)];
      send_symbol(s, i == len - 1);
    end
  endtask

  // --------------------------------------------------------------- tests
  // Reset value of the limit, then a directed string and a single-byte string at that limit
  task automatic test_reset_limit();
    logic [lwkd_pkg::CFG_DATA_W-1:0] rd;
    logic [7:0] syms[10];
    cfg_read(rd);
    if (rd[lwkd_pkg::MAXD_W-1:0] !== lwkd_pkg::MAX_DISTINCT_RST) begin
      $error("max_distinct: expected %0d, got %0d", lwkd_pkg::MAX_DISTINCT_RST,
             rd[lwkd_pkg::MAXD_W-1:0]);
      fail_count++;
    end
    syms = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'h80, 8'h7F, 8'h7F, 8'h80, 8'h01};
    foreach (syms[i]) send_symbol(syms[i], i == 9);
    // single-byte string
    send_symbol(8'hAA, 1'b1);
    settle();
  endtask

  // A limit of zero empties the window on every symbol
  task automatic test_limit_zero();
    set_limit(8'd0);
    send_symbol(8'h12, 1'b0);
    send_symbol(8'h34, 1'b0);
    send_symbol(8'h34, 1'b1);
    settle();
  endtask

  // Smallest and largest non-zero limits
  task automatic test_limit_extremes();
    set_limit(8'd1);
    send_symbol(8'h55, 1'b0);
    send_symbol(8'h55, 1'b0);
    send_symbol(8'hAA, 1'b0);
    send_symbol(8'hAA, 1'b0);
    send_symbol(8'hAA, 1'b1);
    settle();
    set_limit(8'd255);
    for (int i = 1; i <= 6; i++) send_symbol(8'(i), i == 6);
    settle();
  endtask

  // Window outgrows the buffer; the flag must clear with the next string
  task automatic test_buffer_full();
    set_limit(8'd2);
    for (int i = 0; i < DEPTH + 40; i++)
      send_symbol($urandom_range(1) ? 8'h3C : 8'hC3, i == DEPTH + 39);
    send_string(3, 2, 0);
    settle();
  endtask

  // Hold the receiver off long enough for the block to stall its input
  task automatic test_output_stall();
    set_limit(8'd3);
    @(posedge clk);
    stall_cycles = 400;
    send_string(40, 4, 10);
    settle();
  endtask

  // Random strings over phases of random limits
  task automatic test_random_strings();
    int sent_at_start;
    int phase;
    int phase_len;
    int phase_start;
    int pool_cap;
    logic [lwkd_pkg::MAXD_W-1:0] lim;
    sent_at_start = n_symbols;
    phase = 0;
    while (n_symbols - sent_at_start < RANDOM_SYMS) begin
      case ($urandom_range(9))
        0:       lim = 8'd1;
        1:       lim = 8'd2;
        2:       lim = 8'd3;
        3, 4, 5: lim = 8'($urandom_range(2, 8));
        6:       lim = 8'd255;
        7:       lim = 8'd0;
        default: lim = limit_model;
      endcase
      set_limit(lim);
      // one phase runs with no idling on either side
      in_gaps_on  = (phase != 2);
      out_gaps_on = (phase != 2);
      pool_cap    = (lim > 14) ? 16 : lim + 2;
      phase_len   = $urandom_range(150, 250);
      phase_start = n_symbols;
      while (n_symbols - phase_start < phase_len) begin
        send_string(($urandom_range(9) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 40),
                    $urandom_range(1, pool_cap), 10);
        // drop the accepted byte before the next string starts
        @(negedge clk);
        in_ch.valid <= 1'b0;
      end
      settle();
      phase++;
    end
    in_gaps_on  = 1'b1;
    out_gaps_on = 1'b1;
  endtask

  // ----------------------------------------------------------- sequence
  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.symbol      = '0;
    in_ch.last_symbol = 1'b0;
    out_ch.ready      = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    fail_count        = 0;
    n_results         = 0;
    n_strings         = 0;
    n_symbols         = 0;
    stall_cycles      = 0;
    in_gaps_on        = 1'b1;
    out_gaps_on       = 1'b1;
    clear_string();
    limit_model = lwkd_pkg::MAX_DISTINCT_RST;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_limit();
    test_limit_zero();
    test_limit_extremes();
    test_buffer_full();
    test_output_stall();
    test_random_strings();

    settle();
    // let any stray result surface
    repeat (20) @(posedge clk);

    $display("Checked %0d results over %0d strings (%0d symbols), limits from 0 to 255,",
             n_results, n_strings, n_symbols);
    $display("including a buffer overflow and a long receiver hold-off.");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

endmodule
